[sv/dqr_pkg.sv]
package dqr_pkg;

   // Number of cells in the chain and the width of a stored value.
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 16;

   // Field widths fixed by the stream format.
   localparam int OP_WIDTH     = 3;
   localparam int KEY_WIDTH    = 16;
   localparam int STATUS_WIDTH = 2;
   localparam int CNT_OUT_W    = 5;
   localparam int REQ_BYTES_W  = 24;
   localparam int RSP_BYTES_W  = 24;

   // Values are masked to the port width, so a cell never needs more bits than that.
   localparam int ENTRY_WIDTH = (VALUE_WIDTH < KEY_WIDTH) ? VALUE_WIDTH : KEY_WIDTH;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef logic [ENTRY_WIDTH-1:0] entry_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_REAR   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_REMOVE     = 3'd4,
      OP_PEEK_FRONT = 3'd5,
      OP_PEEK_REAR  = 3'd6
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Commands broadcast from the control logic to every cell of the chain.
   typedef struct packed {
      logic shift_right;  // push at the front
      logic shift_left;   // pop at the front
      logic remove;       // close the gap at the first match
      logic load_rear;    // push at the rear
      logic drop_rear;    // pop at the rear
   } cell_ctrl_type;

endpackage

[sv/dqr_cell.sv]
module dqr_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dqr_pkg::cell_ctrl_type ctrl,
   input  dqr_pkg::entry_type     key,
   input  dqr_pkg::entry_type     left_data,
   input  logic                   left_valid,
   input  dqr_pkg::entry_type     right_data,
   input  logic                   right_valid,
   input  logic                   match_in,
   input  dqr_pkg::entry_type     rear_in,
   output dqr_pkg::entry_type     data,
   output logic                   valid,
   output logic                   match_out,
   output dqr_pkg::entry_type     rear_out
);

   dqr_pkg::entry_type data_ff, data_in;
   logic               valid_ff, valid_in;
   logic               hit;
   logic               is_last;

   assign hit       = valid_ff && (data_ff == key);
   assign match_out = match_in | hit;
   assign is_last   = valid_ff && !right_valid;
   assign rear_out  = rear_in | (is_last ? data_ff : '0);

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.shift_right) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.shift_left || (ctrl.remove && match_out)) begin
         // Every cell at or behind the removed entry takes its rear neighbor's word.
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.load_rear && !valid_ff && left_valid) begin
         data_in  = key;
         valid_in = 1'b1;
      end else if (ctrl.drop_rear && is_last) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

[sv/deque_with_remove_by_value.sv]
// Each response word is registered: it is loaded on the clock edge that accepts its request.
// Throughput: one word per cycle; a response held by a stalled consumer blocks new requests
// only while it is not being taken, since the response register refills in the same cycle.
// The rate is set by the cell chain, where all cells compare and shift together.
// Reset (synchronous, active high) empties the queue and drops any pending response.
module deque_with_remove_by_value (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] opcode, [18:3] value, [23:19] zero
   input  logic [dqr_pkg::REQ_BYTES_W-1:0]   req_tdata,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [17:2] out_value, [22:18] count, [23] zero
   output logic [dqr_pkg::RSP_BYTES_W-1:0]   rsp_tdata
);

   localparam int D = dqr_pkg::DEPTH;

   // Request fields. The value is masked to the width a cell stores.
   dqr_pkg::op_type    op;
   dqr_pkg::entry_type key;
   logic               req_take;

   assign op       = dqr_pkg::op_type'(req_tdata[dqr_pkg::OP_WIDTH-1:0]);
   assign key      = req_tdata[dqr_pkg::OP_WIDTH +: dqr_pkg::ENTRY_WIDTH];
   assign req_take = req_tvalid && req_tready;

   // Occupancy count, kept beside the chain for the status and count fields.
   dqr_pkg::count_type count_ff, count_in;
   logic               is_empty, is_full;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == dqr_pkg::COUNT_WIDTH'(D));

   // The chain of cells. Cell 0 is the front. Match and rear values ripple from front to rear.
   dqr_pkg::cell_ctrl_type ctrl;
   dqr_pkg::entry_type     cell_data  [D];
   logic                   cell_valid [D];
   logic                   match_chain[D+1];
   dqr_pkg::entry_type     rear_chain [D+1];

   assign match_chain[0] = 1'b0;
   assign rear_chain[0]  = '0;

   for (genvar i = 0; i < D; i++) begin : g_cell
      dqr_pkg::entry_type left_data, right_data;
      logic               left_valid, right_valid;

      if (i == 0) begin : g_front
         // A push at the front shifts the key in; a rear push into an empty queue lands here.
         assign left_data  = key;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == D - 1) begin : g_rear
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      dqr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (key),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .match_in    (match_chain[i]),
         .rear_in     (rear_chain[i]),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .match_out   (match_chain[i+1]),
         .rear_out    (rear_chain[i+1])
      );
   end

   // Decode the opcode into cell commands, the response fields and the next count.
   // Failing operations (push when full, pop when empty, removal without a match) leave the
   // chain alone. The removed value equals the key, so the key is returned for a removal.
   dqr_pkg::status_type status;
   dqr_pkg::entry_type  result;
   logic                found;

   assign found = match_chain[D];

   always_comb begin
      ctrl     = '0;
      status   = dqr_pkg::ST_OK;
      result   = '0;
      count_in = count_ff;
      unique case (op)
         dqr_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               status = dqr_pkg::ST_FULL;
            end else begin
               ctrl.shift_right = req_take;
               count_in         = count_ff + 1'b1;
            end
         end
         dqr_pkg::OP_PUSH_REAR: begin
            if (is_full) begin
               status = dqr_pkg::ST_FULL;
            end else begin
               ctrl.load_rear = req_take;
               count_in       = count_ff + 1'b1;
            end
         end
         dqr_pkg::OP_POP_REAR: begin
            if (is_empty) begin
               status = dqr_pkg::ST_EMPTY;
            end else begin
               ctrl.drop_rear = req_take;
               result         = rear_chain[D];
               count_in       = count_ff - 1'b1;
            end
         end
         dqr_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status = dqr_pkg::ST_EMPTY;
            end else begin
               ctrl.shift_left = req_take;
               result          = cell_data[0];
               count_in        = count_ff - 1'b1;
            end
         end
         dqr_pkg::OP_REMOVE: begin
            if (found) begin
               ctrl.remove = req_take;
               result      = key;
               count_in    = count_ff - 1'b1;
            end else begin
               status = dqr_pkg::ST_NOT_FOUND;
            end
         end
         dqr_pkg::OP_PEEK_FRONT: begin
            if (is_empty) begin
               status = dqr_pkg::ST_EMPTY;
            end else begin
               result = cell_data[0];
            end
         end
         dqr_pkg::OP_PEEK_REAR: begin
            if (is_empty) begin
               status = dqr_pkg::ST_EMPTY;
            end else begin
               result = rear_chain[D];
            end
         end
         default: begin
            // The unused opcode changes nothing and answers ok with a zero value.
         end
      endcase
   end

   // Response register. It accepts a new word whenever it is empty or being drained.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dqr_pkg::RSP_BYTES_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0,
                         dqr_pkg::CNT_OUT_W'(count_in),
                         dqr_pkg::KEY_WIDTH'(result),
                         status};
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[bench/testbench.sv]
module testbench;

   // Opcode seven is not decoded by the block; it must leave the queue alone.
   localparam logic [dqr_pkg::OP_WIDTH-1:0] OP_UNUSED = 3'd7;

   localparam int DIRECTED_ROWS   = 19;
   localparam int WORDS_PER_PHASE = 240;
   localparam int PHASES          = 4;
   localparam int KEY_POOL_SIZE   = 8;
   // The block answers in the cycle after it takes a request; a few spare cycles
   // at the end catch any stray response word.
   localparam int TAIL_CYCLES     = 4;

   // One response word, unpacked into its fields.
   typedef struct packed {
      dqr_pkg::status_type                 status;
      logic [dqr_pkg::KEY_WIDTH-1:0]       value;
      logic [dqr_pkg::CNT_OUT_W-1:0]       count;
   } deque_reply_type;

   // One line of the directed table. A line with reps above one pushes a run of
   // consecutive values starting at its value. Where typed is set, the reply
   // written in the line is the expected one; otherwise the shadow deque decides.
   typedef struct packed {
      logic [dqr_pkg::OP_WIDTH-1:0]  op;
      logic [dqr_pkg::KEY_WIDTH-1:0] value;
      int                            reps;
      bit                            typed;
      deque_reply_type               reply;
   } stim_row_type;

   // Expectation fixed by the sender for one request word, consumed when the
   // word is accepted.
   typedef struct packed {
      bit              typed;
      deque_reply_type reply;
   } pinned_reply_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // [2:0] opcode, [18:3] value, [23:19] zero
   logic [dqr_pkg::REQ_BYTES_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [1:0] status, [17:2] out_value, [22:18] count, [23] zero
   logic [dqr_pkg::RSP_BYTES_W-1:0] rsp_tdata;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int idle_pct  = 0;
   int stall_pct = 0;
   int failures  = 0;

   // Shadow copy of the deque: cells from the front, and how many are held.
   dqr_pkg::entry_type shadow_cells [dqr_pkg::DEPTH];
   int                 shadow_fill = 0;

   pinned_reply_type pinned_q [$];
   deque_reply_type  expected_reply_q [$];

   // The empty-queue cases come first, straight after reset. Then the queue is
   // filled to the brim so that pushes bounce, a value is pulled from the
   // middle, and a duplicate is placed at the front to check that removal
   // takes the copy nearest the front.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{dqr_pkg::OP_POP_REAR,   16'h0000,  1, 1'b1, '{dqr_pkg::ST_EMPTY, 16'h0000, 5'd0}},
      '{dqr_pkg::OP_POP_FRONT,  16'hFFFF,  1, 1'b1, '{dqr_pkg::ST_EMPTY, 16'h0000, 5'd0}},
      '{dqr_pkg::OP_PEEK_FRONT, 16'h0000,  1, 1'b1, '{dqr_pkg::ST_EMPTY, 16'h0000, 5'd0}},
      '{dqr_pkg::OP_PEEK_REAR,  16'hFFFF,  1, 1'b1, '{dqr_pkg::ST_EMPTY, 16'h0000, 5'd0}},
      '{dqr_pkg::OP_REMOVE,     16'h1234,  1, 1'b1,
        '{dqr_pkg::ST_NOT_FOUND, 16'h0000, 5'd0}},
      '{OP_UNUSED,              16'hFFFF,  1, 1'b1, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{dqr_pkg::OP_PUSH_REAR,  16'hFFFF,  1, 1'b1, '{dqr_pkg::ST_OK,    16'h0000, 5'd1}},
      '{dqr_pkg::OP_PUSH_FRONT, 16'h0000,  1, 1'b1, '{dqr_pkg::ST_OK,    16'h0000, 5'd2}},
      '{dqr_pkg::OP_PEEK_REAR,  16'h0000,  1, 1'b1, '{dqr_pkg::ST_OK,    16'hFFFF, 5'd2}},
      '{dqr_pkg::OP_PUSH_REAR,  16'hA5A0, 14, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{dqr_pkg::OP_PUSH_FRONT, 16'h5555,  1, 1'b1, '{dqr_pkg::ST_FULL,  16'h0000, 5'd16}},
      '{dqr_pkg::OP_PUSH_REAR,  16'hAAAA,  1, 1'b1, '{dqr_pkg::ST_FULL,  16'h0000, 5'd16}},
      '{dqr_pkg::OP_REMOVE,     16'hA5A6,  1, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{dqr_pkg::OP_REMOVE,     16'h1234,  1, 1'b1,
        '{dqr_pkg::ST_NOT_FOUND, 16'h0000, 5'd15}},
      '{dqr_pkg::OP_POP_FRONT,  16'h0000,  1, 1'b1, '{dqr_pkg::ST_OK,    16'h0000, 5'd14}},
      '{dqr_pkg::OP_POP_REAR,   16'h0000,  1, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{dqr_pkg::OP_PUSH_FRONT, 16'hA5A3,  1, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{dqr_pkg::OP_REMOVE,     16'hA5A3,  1, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}},
      '{OP_UNUSED,              16'h0000,  1, 1'b0, '{dqr_pkg::ST_OK,    16'h0000, 5'd0}}
   };

   // Idling per phase: none, sender mostly idle, receiver mostly stalled, and
   // both lightly.
   int phase_idle  [PHASES] = '{0, 82, 0, 10};
   int phase_stall [PHASES] = '{0, 0, 82, 10};

   deque_with_remove_by_value dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs a handshake.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   // Apply one request word to the shadow deque and return the reply that the
   // block should give for it.
   function automatic deque_reply_type apply_to_shadow(
      input logic [dqr_pkg::OP_WIDTH-1:0]  op,
      input logic [dqr_pkg::KEY_WIDTH-1:0] key);
      deque_reply_type    reply;
      dqr_pkg::entry_type item;
      int                 i;
      int                 hit;
      item         = dqr_pkg::entry_type'(key);
      reply.status = dqr_pkg::ST_OK;
      reply.value  = '0;
      hit          = -1;
      case (op)
         dqr_pkg::OP_PUSH_FRONT: begin
            if (shadow_fill >= dqr_pkg::DEPTH) begin
               reply.status = dqr_pkg::ST_FULL;
            end else begin
               for (i = shadow_fill; i > 0; i--)
                  shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[0] = item;
               shadow_fill++;
            end
         end
         dqr_pkg::OP_PUSH_REAR: begin
            if (shadow_fill >= dqr_pkg::DEPTH) begin
               reply.status = dqr_pkg::ST_FULL;
            end else begin
               shadow_cells[shadow_fill] = item;
               shadow_fill++;
            end
         end
         dqr_pkg::OP_POP_REAR, dqr_pkg::OP_PEEK_REAR: begin
            if (shadow_fill == 0) begin
               reply.status = dqr_pkg::ST_EMPTY;
            end else begin
               reply.value = dqr_pkg::KEY_WIDTH'(shadow_cells[shadow_fill-1]);
               if (op == dqr_pkg::OP_POP_REAR)
                  shadow_fill--;
            end
         end
         dqr_pkg::OP_POP_FRONT, dqr_pkg::OP_PEEK_FRONT: begin
            if (shadow_fill == 0) begin
               reply.status = dqr_pkg::ST_EMPTY;
            end else begin
               reply.value = dqr_pkg::KEY_WIDTH'(shadow_cells[0]);
               if (op == dqr_pkg::OP_POP_FRONT)
                  hit = 0;
            end
         end
         dqr_pkg::OP_REMOVE: begin
            reply.status = dqr_pkg::ST_NOT_FOUND;
            for (i = shadow_fill - 1; i >= 0; i--)
               if (shadow_cells[i] == item)
                  hit = i;
            if (hit >= 0) begin
               reply.status = dqr_pkg::ST_OK;
               reply.value  = dqr_pkg::KEY_WIDTH'(shadow_cells[hit]);
            end
         end
         default: begin
            // The unused opcode changes nothing.
         end
      endcase
      // Popping at the front and removal both close the gap left at the hit.
      if (hit >= 0) begin
         for (i = hit; i < shadow_fill - 1; i++)
            shadow_cells[i] = shadow_cells[i+1];
         shadow_fill--;
      end
      reply.count = dqr_pkg::CNT_OUT_W'(shadow_fill);
      return reply;
   endfunction

   // Both handshakes are sampled at the rising edge, before the block and the
   // drivers update anything for the next cycle. An accepted request turns
   // into an expectation first, so the order would still hold if a response
   // came in the same cycle as its request.
   always @(posedge clock) begin : scoreboard
      deque_reply_type  want;
      deque_reply_type  shadow_reply;
      pinned_reply_type pin;
      if (reset) begin
         shadow_fill = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            shadow_reply = apply_to_shadow(req_tdata[2:0], req_tdata[18:3]);
            pin          = pinned_q.pop_front();
            expected_reply_q.push_back(pin.typed ? pin.reply : shadow_reply);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reply_q.size() == 0) begin
               $error("response word 0x%06h with no request outstanding", rsp_tdata);
               failures++;
            end else begin
               want = expected_reply_q.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
                  failures++;
               end
               if (rsp_tdata[17:2] !== want.value) begin
                  $error("out_value: expected 0x%04h, actual 0x%04h",
                         want.value, rsp_tdata[17:2]);
                  failures++;
               end
               if (rsp_tdata[22:18] !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_tdata[22:18]);
                  failures++;
               end
            end
         end
      end
   end

   // The receiver draws a fresh stall decision every cycle.
   always @(posedge clock) begin
      rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // Offer one request word, after a random number of idle cycles, and return
   // at the edge where it is taken. The valid is only lowered while idling, so
   // back-to-back words keep it high without a glitch.
   task automatic send_word(input logic [dqr_pkg::OP_WIDTH-1:0]  op,
                            input logic [dqr_pkg::KEY_WIDTH-1:0] key,
                            input bit typed, input deque_reply_type reply);
      pinned_reply_type pin;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pin.typed = typed;
      pin.reply = reply;
      pinned_q.push_back(pin);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, key, op};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every expected response has come back. The
   // first edge lets the last accepted word reach the scoreboard.
   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reply_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      deque_reply_type               no_reply;
      logic [dqr_pkg::OP_WIDTH-1:0]  op;
      logic [dqr_pkg::KEY_WIDTH-1:0] key;
      logic [dqr_pkg::KEY_WIDTH-1:0] key_pool [KEY_POOL_SIZE];
      bit                            filling;
      int                            run_left;
      int                            roll;
      int                            rep;
      int                            n;
      no_reply = '{dqr_pkg::ST_OK, '0, '0};
      filling  = 1'b0;
      run_left = 0;
      // A small pool of keys makes removals hit often and brings duplicates.
      foreach (key_pool[k])
         key_pool[k] = dqr_pkg::KEY_WIDTH'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (rep = 0; rep < directed_rows[r].reps; rep++)
            send_word(directed_rows[r].op,
                      directed_rows[r].value + dqr_pkg::KEY_WIDTH'(rep),
                      directed_rows[r].typed, directed_rows[r].reply);
      end
      wait_for_replies();

      // Random traffic alternates between runs that mostly push and runs that
      // mostly pop or remove, so the queue keeps swinging between full and
      // empty. A few unused opcodes are mixed in as noise. The sender pauses
      // for all responses at the end of each phase.
      for (int p = 0; p < PHASES; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            if (run_left == 0) begin
               filling  = !filling;
               run_left = $urandom_range(45, 20);
            end
            run_left--;
            roll = $urandom_range(99);
            if (filling) begin
               if      (roll < 30) op = dqr_pkg::OP_PUSH_FRONT;
               else if (roll < 60) op = dqr_pkg::OP_PUSH_REAR;
               else if (roll < 68) op = dqr_pkg::OP_POP_REAR;
               else if (roll < 72) op = dqr_pkg::OP_POP_FRONT;
               else if (roll < 84) op = dqr_pkg::OP_REMOVE;
               else if (roll < 90) op = dqr_pkg::OP_PEEK_FRONT;
               else if (roll < 97) op = dqr_pkg::OP_PEEK_REAR;
               else                op = OP_UNUSED;
            end else begin
               if      (roll < 8)  op = dqr_pkg::OP_PUSH_FRONT;
               else if (roll < 16) op = dqr_pkg::OP_PUSH_REAR;
               else if (roll < 40) op = dqr_pkg::OP_POP_REAR;
               else if (roll < 60) op = dqr_pkg::OP_POP_FRONT;
               else if (roll < 82) op = dqr_pkg::OP_REMOVE;
               else if (roll < 88) op = dqr_pkg::OP_PEEK_FRONT;
               else if (roll < 96) op = dqr_pkg::OP_PEEK_REAR;
               else                op = OP_UNUSED;
            end
            if ($urandom_range(99) < 60)
               key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            else
               key = dqr_pkg::KEY_WIDTH'($urandom);
            send_word(op, key, 1'b0, no_reply);
         end
         wait_for_replies();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
